>>> rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants, codes and controller/datapath interface types for the
// sparse polynomial multiplier.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int MAX_EXP_DEF   = 15;

  localparam int KIND_W  = 3;
  localparam int TEXP_W  = 4;
  localparam int TCOEF_W = 16;
  localparam int STAT_W  = 2;
  localparam int REXP_W  = 5;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 2 * TCOEF_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_ADD_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLR_A = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLR_B = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STS_PRODUCT = 2'd0;
  localparam logic [STAT_W-1:0] STS_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STS_FULL    = 2'd2;

  typedef struct packed {
    logic                load_a;
    logic                load_b;
    logic                clr_a;
    logic                clr_b;
    logic                pair_rst;
    logic                pair_adv;
    logic                mul_en;
    logic                sum_rd_pair;
    logic                sum_wr_acc;
    logic                sum_wr_zero;
    logic                e_load_top;
    logic                e_dec;
    logic                e_inc;
    logic                out_load;
    logic [STAT_W-1:0]   out_status;
  } spm_cmd_t;

  typedef struct packed {
    logic a_empty;
    logic b_empty;
    logic a_full;
    logic b_full;
    logic pair_last;
    logic e_zero;
    logic e_clr_last;
    logic out_free;
  } spm_sts_t;

endpackage

>>> rtl/spm_ctrl.sv
// ----------------------------------------------------------------------------
// spm_ctrl
// Controller: decodes input beats and sequences the clearing pass, the
// pair walk, and the emission of the product terms and status results.
// ----------------------------------------------------------------------------
module spm_ctrl
  import spm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_tready,
  output spm_cmd_t          cmd,
  input  spm_sts_t          sts
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_STAT = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_ERD  = 3'd6;
  localparam logic [2:0] ST_EOUT = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.sum_wr_zero = 1'b1;
        cmd.e_inc       = 1'b1;
        if (sts.e_clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_ADD_A: begin
              if (sts.a_full) begin
                stat_nxt  = STS_FULL;
                state_nxt = ST_STAT;
              end else begin
                cmd.load_a = 1'b1;
              end
            end
            KIND_ADD_B: begin
              if (sts.b_full) begin
                stat_nxt  = STS_FULL;
                state_nxt = ST_STAT;
              end else begin
                cmd.load_b = 1'b1;
              end
            end
            KIND_CLR_A: cmd.clr_a = 1'b1;
            KIND_CLR_B: cmd.clr_b = 1'b1;
            KIND_MUL: begin
              if (sts.a_empty || sts.b_empty) begin
                stat_nxt  = STS_EMPTY;
                state_nxt = ST_STAT;
              end else begin
                cmd.pair_rst = 1'b1;
                state_nxt    = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = stat_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en      = 1'b1;
        cmd.sum_rd_pair = 1'b1;
        state_nxt       = ST_ACC;
      end
      ST_ACC: begin
        cmd.sum_wr_acc = 1'b1;
        cmd.pair_adv   = 1'b1;
        if (sts.pair_last) begin
          cmd.e_load_top = 1'b1;
          state_nxt      = ST_ERD;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_ERD: begin
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        if (sts.out_free) begin
          // emit and zero the accumulator for the next multiply
          cmd.out_load    = 1'b1;
          cmd.out_status  = STS_PRODUCT;
          cmd.sum_wr_zero = 1'b1;
          if (sts.e_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.e_dec = 1'b1;
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register occupied");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (!sts.a_empty && !sts.b_empty))
    else $error("pair walk started with an empty store");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EOUT && sts.out_free && sts.e_zero) |=> (state_r == ST_IDLE))
    else $error("emission did not finish after exponent zero");
`endif

endmodule

>>> rtl/spm_dpath.sv
// ----------------------------------------------------------------------------
// spm_dpath
// Datapath: term stores, counts and maxima, pair multiplier, accumulator
// memory and the output register.
// ----------------------------------------------------------------------------
module spm_dpath
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int MAX_EXP   = MAX_EXP_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TEXP_W-1:0]        in_term_exp,
  input  logic signed [TCOEF_W-1:0] in_term_coeff,
  input  spm_cmd_t                 cmd,
  output spm_sts_t                 sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [STAT_W-1:0]        out_status,
  output logic [REXP_W-1:0]        out_result_exp,
  output logic signed [ACC_W-1:0]  out_result_coeff,
  output logic                     out_tlast
);

  localparam int CW        = $clog2(MAX_TERMS + 1);
  localparam int AW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int EW        = $clog2(MAX_EXP + 1);
  localparam int SUM_DEPTH = 2 * MAX_EXP + 1;
  localparam int SW        = $clog2(SUM_DEPTH);
  localparam int XW        = (EW > TEXP_W) ? EW : TEXP_W;
  localparam int TW        = EW + TCOEF_W;

  logic [TW-1:0]    mem_a [MAX_TERMS];
  logic [TW-1:0]    mem_b [MAX_TERMS];
  logic [ACC_W-1:0] sums_mem [SUM_DEPTH];

  logic [CW-1:0] count_a_r, count_b_r;
  logic [EW-1:0] max_a_r, max_b_r;
  logic [AW-1:0] i_r, j_r;
  logic [SW-1:0] e_r, pe_r;
  logic [TW-1:0] rd_a_r, rd_b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0] sum_rd_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [REXP_W-1:0] out_exp_r;
  logic [ACC_W-1:0]  out_coeff_r;
  logic              out_last_r;

  logic [EW-1:0] exp_sat;
  logic [SW-1:0] pair_exp;
  logic [SW-1:0] sum_raddr;
  logic [SW-1:0] sum_waddr;
  logic [ACC_W-1:0] sum_wdata;
  logic          i_last;

  // clamp the incoming exponent to the largest storable one
  assign exp_sat = (XW'(in_term_exp) > XW'(MAX_EXP)) ? EW'(MAX_EXP) : EW'(in_term_exp);

  assign pair_exp  = SW'(rd_a_r[TW-1:TCOEF_W]) + SW'(rd_b_r[TW-1:TCOEF_W]);
  assign sum_raddr = cmd.sum_rd_pair ? pair_exp : e_r;
  assign sum_waddr = cmd.sum_wr_acc ? pe_r : e_r;
  assign sum_wdata = cmd.sum_wr_acc ? (sum_rd_r + ACC_W'(prod_r)) : '0;
  assign i_last    = (CW'(i_r) == count_a_r - CW'(1));

  assign sts.a_empty    = (count_a_r == '0);
  assign sts.b_empty    = (count_b_r == '0);
  assign sts.a_full     = (count_a_r >= CW'(MAX_TERMS));
  assign sts.b_full     = (count_b_r >= CW'(MAX_TERMS));
  assign sts.pair_last  = i_last && (CW'(j_r) == count_b_r - CW'(1));
  assign sts.e_zero     = (e_r == '0);
  assign sts.e_clr_last = (e_r == SW'(SUM_DEPTH - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  // store counts and maxima
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
      max_a_r   <= '0;
      max_b_r   <= '0;
    end else begin
      if (cmd.clr_a) begin
        count_a_r <= '0;
        max_a_r   <= '0;
      end else if (cmd.load_a) begin
        count_a_r <= count_a_r + CW'(1);
        if (exp_sat > max_a_r) begin
          max_a_r <= exp_sat;
        end
      end
      if (cmd.clr_b) begin
        count_b_r <= '0;
        max_b_r   <= '0;
      end else if (cmd.load_b) begin
        count_b_r <= count_b_r + CW'(1);
        if (exp_sat > max_b_r) begin
          max_b_r <= exp_sat;
        end
      end
    end
  end

  // term stores
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      mem_a[count_a_r[AW-1:0]] <= {exp_sat, in_term_coeff};
    end
    if (cmd.load_b) begin
      mem_b[count_b_r[AW-1:0]] <= {exp_sat, in_term_coeff};
    end
    rd_a_r <= mem_a[i_r];
    rd_b_r <= mem_b[j_r];
  end

  // pair walk: A inner, B outer
  always_ff @(posedge clk) begin
    if (cmd.pair_rst) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.pair_adv) begin
      if (i_last) begin
        i_r <= '0;
        j_r <= j_r + AW'(1);
      end else begin
        i_r <= i_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= $signed(rd_a_r[TCOEF_W-1:0]) * $signed(rd_b_r[TCOEF_W-1:0]);
      pe_r   <= pair_exp;
    end
  end

  // exponent counter also drives the clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r <= '0;
    end else if (cmd.e_load_top) begin
      e_r <= SW'(max_a_r) + SW'(max_b_r);
    end else if (cmd.e_dec) begin
      e_r <= e_r - SW'(1);
    end else if (cmd.e_inc) begin
      e_r <= e_r + SW'(1);
    end
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (cmd.sum_wr_acc || cmd.sum_wr_zero) begin
      sums_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_r <= sums_mem[sum_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      if (cmd.out_status == STS_PRODUCT) begin
        out_exp_r   <= REXP_W'(e_r);
        out_coeff_r <= sum_rd_r;
        out_last_r  <= (e_r == '0);
      end else begin
        out_exp_r   <= '0;
        out_coeff_r <= '0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_exp   = out_exp_r;
  assign out_result_coeff = $signed(out_coeff_r);
  assign out_tlast        = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CW'(MAX_TERMS)) && (count_b_r <= CW'(MAX_TERMS)))
    else $error("term count above store depth");

  a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_a |-> !sts.a_full) and (cmd.load_b |-> !sts.b_full))
    else $error("term written into a full store");

  a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_status == STS_PRODUCT && e_r == '0) |=> out_tlast)
    else $error("exponent zero term not marked last");
`endif

endmodule

>>> rtl/sparse_polynomial_multiplier_top.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_multiplier_top
// Multiplies two sparse polynomials held in term stores A and B and
// streams the product terms from the highest exponent down to zero.
//
//   channel | dir | tdata fields (low bit up)              | tuser   | tlast
//   in_     | in  | term_exp[3:0], term_coeff[19:4]        | kind    | -
//   out_    | out | result_exp[4:0], result_coeff[44:5]    | status  | last
//
// A multiply walks every pair of A and B terms through a single
// multiplier and a read-modify-write of the accumulator memory, each pair
// passing the read, multiply and accumulate states in turn, then emits
// one term per exponent from top = max(expA)+max(expB) down to zero.
// After reset the accumulator memory, all 2*MAX_EXP+1 entries, is zeroed
// before the first beat is taken. A stall on the output holds the sequence.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiplier_top
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int MAX_EXP   = MAX_EXP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // term_exp, term_coeff
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_exp, result_coeff
  output logic [STAT_W-1:0]     out_tuser,  // status
  output logic                  out_tlast
);

  spm_cmd_t cmd;
  spm_sts_t sts;

  logic [REXP_W-1:0]       result_exp;
  logic signed [ACC_W-1:0] result_coeff;

  spm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  spm_dpath #(
    .MAX_TERMS (MAX_TERMS),
    .MAX_EXP   (MAX_EXP)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_term_exp      (in_tdata[TEXP_W-1:0]),
    .in_term_coeff    ($signed(in_tdata[TEXP_W+TCOEF_W-1:TEXP_W])),
    .cmd              (cmd),
    .sts              (sts),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (out_tuser),
    .out_result_exp   (result_exp),
    .out_result_coeff (result_coeff),
    .out_tlast        (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - REXP_W - ACC_W){1'b0}}, result_coeff, result_exp};

endmodule
